### hw/rtl/ssvt_pkg.sv
// ----------------------------------------------------------------------------
// ssvt_pkg
// Shared types and constants for the sorted sparse vector table.
// ----------------------------------------------------------------------------
`default_nettype none

package ssvt_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned IN_INDEX_W     = 16;
  localparam int unsigned COUNT_OUT_W    = 7;
  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned INDEX_BITS_DEF = 16;
  localparam int unsigned CMP_W          = 32;

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_GET = 2'd1,
    OP_ADD = 2'd2,
    OP_SUB = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK,
    ST_CMP,
    ST_EVAL,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_FINISH
  } state_e;

  // Request to the shared compare / add unit
  typedef struct packed {
    logic [CMP_W-1:0]  cmp_a;
    logic [CMP_W-1:0]  cmp_b;
    logic [DATA_W-1:0] add_a;
    logic [DATA_W-1:0] add_b;
    logic              add_sub;
  } alu_req_t;

  typedef struct packed {
    logic              lt;
    logic              eq;
    logic [DATA_W-1:0] sum;
    logic              sum_zero;
  } alu_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/ssvt_alu.sv
// ----------------------------------------------------------------------------
// ssvt_alu
// Shared index compare and wrapping add/subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ssvt_alu (
  input  ssvt_pkg::alu_req_t req_i,
  output ssvt_pkg::alu_rsp_t rsp_o
);
  import ssvt_pkg::*;

  logic [DATA_W-1:0] addend;

  // Subtract as add of the inverted operand plus one; wraps in 32 bits
  assign addend       = req_i.add_b ^ {DATA_W{req_i.add_sub}};
  assign rsp_o.sum    = req_i.add_a + addend + DATA_W'(req_i.add_sub);
  assign rsp_o.sum_zero = (rsp_o.sum == '0);
  assign rsp_o.lt     = (req_i.cmp_a < req_i.cmp_b);
  assign rsp_o.eq     = (req_i.cmp_a == req_i.cmp_b);

endmodule

`default_nettype wire

### hw/rtl/ssvt_store.sv
// ----------------------------------------------------------------------------
// ssvt_store
// Entry memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssvt_store #(
  parameter int unsigned DEPTH   = 64,
  parameter int unsigned WIDTH   = 48,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### hw/rtl/sorted_sparse_vector_table.sv
// ----------------------------------------------------------------------------
// sorted_sparse_vector_table
// Sparse integer vector kept as (index, value) pairs sorted by index in one
// memory, updated by a sequencer around a shared compare/add unit.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake                     payload
//  -------  ---  ----------------------------  ---------------------------------
//  s_axis   in   s_axis_tvalid / s_axis_tready  tuser: opcode; tdata: index, value
//  m_axis   out  m_axis_tvalid / m_axis_tready  tuser: status; tdata: value, count
//
// Steps per word: accept; per stored entry below the index, one read and one
// compare on the shared unit; end the scan (fill count reached, or the entry
// at the slot read and compared); evaluate; on insert or removal, one read and
// one write per entry moved plus a step to close the shift loop; the insert
// write; hand-over of the result. The registered memory read sets the pace
// of both scan and shift.
// Reset clears the fill count and the control state only; the memory holds
// no valid bits and needs no clearing pass. A stalled result sits in the
// output register while the next word is already accepted and worked on;
// that word then holds at its hand-over until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_sparse_vector_table #(
  parameter int unsigned CAPACITY   = ssvt_pkg::CAPACITY_DEF,
  parameter int unsigned INDEX_BITS = ssvt_pkg::INDEX_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] entry_index, [47:16] entry_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  // m_axis
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] read_value, [38:32] entry_count, [39] zero
  output logic        m_axis_tuser    // [0] status
);
  import ssvt_pkg::*;

  localparam int unsigned ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned ENTRY_W = INDEX_BITS + DATA_W;

  state_e                state_q, state_d;
  opcode_e               op_q, op_d;
  logic [INDEX_BITS-1:0] key_q, key_d;
  logic [DATA_W-1:0]     val_q, val_d;
  logic [CNT_W-1:0]      p_q, p_d;
  logic [CNT_W-1:0]      q_q, q_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  up_q, up_d;
  logic                  hit_q, hit_d;
  logic [DATA_W-1:0]     cur_q, cur_d;
  logic [DATA_W-1:0]     new_q, new_d;
  logic [DATA_W-1:0]     res_q, res_d;
  logic                  stat_q, stat_d;

  logic                   out_valid_q, out_valid_d;
  logic [DATA_W-1:0]      out_res_q, out_res_d;
  logic                   out_stat_q, out_stat_d;
  logic [COUNT_OUT_W-1:0] out_cnt_q, out_cnt_d;

  logic                  in_fire;
  logic [CMP_W-1:0]      key_wide;
  logic                  wr_en, rd_en;
  logic [ADDR_W-1:0]     wr_addr, rd_addr;
  logic [ENTRY_W-1:0]    wr_data, rd_data;
  logic [INDEX_BITS-1:0] rd_idx;
  logic [DATA_W-1:0]     rd_val;
  logic                  shift_done;
  logic                  load_out;
  alu_req_t              alu_req;
  alu_rsp_t              alu_rsp;

  // Only the low INDEX_BITS of the incoming index count
  assign key_wide = CMP_W'(s_axis_tdata[IN_INDEX_W-1:0]);
  assign rd_idx   = rd_data[ENTRY_W-1:DATA_W];
  assign rd_val   = rd_data[DATA_W-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  ssvt_store #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ssvt_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Shift loop ends when the gap reaches the target slot (insert) or the
  // last occupied slot has been pulled down (remove)
  assign shift_done = up_q ? (q_q == p_q) : ((q_q + CNT_W'(1)) >= count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    val_q      <= val_d;
    p_q        <= p_d;
    q_q        <= q_d;
    up_q       <= up_d;
    hit_q      <= hit_d;
    cur_q      <= cur_d;
    new_q      <= new_d;
    res_q      <= res_d;
    stat_q     <= stat_d;
    out_res_q  <= out_res_d;
    out_stat_q <= out_stat_d;
    out_cnt_q  <= out_cnt_d;
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    key_d    = key_q;
    val_d    = val_q;
    p_d      = p_q;
    q_d      = q_q;
    count_d  = count_q;
    up_d     = up_q;
    hit_d    = hit_q;
    cur_d    = cur_q;
    new_d    = new_q;
    res_d    = res_q;
    stat_d   = stat_q;
    wr_en    = 1'b0;
    wr_addr  = p_q[ADDR_W-1:0];
    wr_data  = {key_q, new_q};
    rd_en    = 1'b0;
    rd_addr  = p_q[ADDR_W-1:0];
    load_out = 1'b0;

    // Shared unit: index compare during the scan, add once per word
    alu_req.cmp_a   = CMP_W'(rd_idx);
    alu_req.cmp_b   = CMP_W'(key_q);
    alu_req.add_a   = (hit_q && (op_q != OP_SET)) ? cur_q : '0;
    alu_req.add_b   = val_q;
    alu_req.add_sub = (op_q == OP_SUB);

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d    = opcode_e'(s_axis_tuser);
          key_d   = key_wide[INDEX_BITS-1:0];
          val_d   = s_axis_tdata[IN_INDEX_W +: DATA_W];
          p_d     = '0;
          hit_d   = 1'b0;
          stat_d  = 1'b0;
          res_d   = '0;
          state_d = ST_SEEK;
        end
      end

      ST_SEEK: begin
        if (p_q == count_q) begin
          hit_d   = 1'b0;
          state_d = ST_EVAL;
        end else begin
          rd_en   = 1'b1;
          state_d = ST_CMP;
        end
      end

      ST_CMP: begin
        if (alu_rsp.lt) begin
          p_d     = p_q + CNT_W'(1);
          state_d = ST_SEEK;
        end else begin
          hit_d   = alu_rsp.eq;
          cur_d   = rd_val;
          state_d = ST_EVAL;
        end
      end

      ST_EVAL: begin
        new_d   = alu_rsp.sum;
        state_d = ST_FINISH;
        if (op_q == OP_GET) begin
          res_d = hit_q ? cur_q : '0;
        end else if (alu_rsp.sum_zero) begin
          // Drop the entry if present; nothing to do otherwise
          if (hit_q) begin
            up_d    = 1'b0;
            q_d     = p_q;
            state_d = ST_SHIFT_RD;
          end
        end else if (hit_q) begin
          wr_en   = 1'b1;
          wr_data = {key_q, alu_rsp.sum};
          res_d   = alu_rsp.sum;
        end else if (count_q == CNT_W'(CAPACITY)) begin
          stat_d = 1'b1;
        end else begin
          res_d   = alu_rsp.sum;
          up_d    = 1'b1;
          q_d     = count_q;
          state_d = ST_SHIFT_RD;
        end
      end

      ST_SHIFT_RD: begin
        if (shift_done) begin
          if (up_q) begin
            state_d = ST_PUT;
          end else begin
            count_d = count_q - CNT_W'(1);
            state_d = ST_FINISH;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = up_q ? ADDR_W'(q_q - CNT_W'(1)) : ADDR_W'(q_q + CNT_W'(1));
          state_d = ST_SHIFT_WR;
        end
      end

      ST_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = q_q[ADDR_W-1:0];
        wr_data = rd_data;
        q_d     = up_q ? (q_q - CNT_W'(1)) : (q_q + CNT_W'(1));
        state_d = ST_SHIFT_RD;
      end

      ST_PUT: begin
        wr_en   = 1'b1;
        count_d = count_q + CNT_W'(1);
        state_d = ST_FINISH;
      end

      ST_FINISH: begin
        // Hold here while the previous result still waits downstream
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: parts the result from the next word's work
  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    out_stat_d  = out_stat_q;
    out_cnt_d   = out_cnt_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_res_d   = res_q;
      out_stat_d  = stat_q;
      out_cnt_d   = COUNT_OUT_W'(count_q);
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_cnt_q, out_res_q};
  assign m_axis_tuser  = out_stat_q;

`ifndef SYNTH
  // Fill count never exceeds the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // One word moves the fill count by at most one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ((count_q == $past(count_q) + CNT_W'(1)) || (count_q == $past(count_q) - CNT_W'(1))))
    else $error("entry count jumped");

  // A dropped insert reports a zero value
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[DATA_W-1:0] == '0))
    else $error("full status with nonzero value");

  // The memory is never written while idle
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !wr_en)
    else $error("memory write while idle");
`endif

endmodule

`default_nettype wire
